FILE: hdl/hex_pixel_unpacker_bgr_top_defines.svh
// Assertion macros shared by the hex pixel unpacker RTL.
// Needs nothing; included by modules that carry concurrent checks.
`ifndef HEX_PIXEL_UNPACKER_BGR_TOP_DEFINES_SVH
`define HEX_PIXEL_UNPACKER_BGR_TOP_DEFINES_SVH

// Same-cycle implication check.
`define HPU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("hpu: same-cycle check failed");

// Next-cycle implication check.
`define HPU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("hpu: next-cycle check failed");

`endif

FILE: hdl/hpu_pkg.sv
// Shared types, constants and helper functions for the hex pixel unpacker.
// No dependencies.
`timescale 1ns / 1ps

package hpu_pkg;

	localparam int MAX_LINES  = 4096;
	localparam int MAX_STRIDE = 12288;

	localparam int LC_W   = 13;   // line_count register
	localparam int LI_W   = 12;   // line index
	localparam int OFS_W  = 14;   // stride and row offsets
	localparam int ADDR_W = 26;
	localparam int CNT_W  = 3;

	localparam logic [CNT_W-1:0] NEED_RGB  = 3'd3;
	localparam logic [CNT_W-1:0] NEED_CMYK = 3'd4;
	localparam logic [OFS_W:0]   PIX_BYTES = 15'd3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		REG_COLOR_MODE  = 2'd0,
		REG_LINE_COUNT  = 2'd1,
		REG_LINE_STRIDE = 2'd2,
		REG_ROW_LAST    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             color_mode;
		logic [LC_W-1:0]  line_count;
		logic [OFS_W-1:0] line_stride;
		logic [OFS_W-1:0] row_last_offset;
	} cfg_t;

	// line index reload on a line_count write
	typedef struct packed {
		logic            we;
		logic [LI_W-1:0] last_line;
	} li_load_t;

	// one entry between front and back
	typedef struct packed {
		logic             wr;
		logic [LI_W-1:0]  line_idx;
		logic [OFS_W-1:0] row_off;
		logic [7:0]       blue;
		logic [7:0]       green;
		logic [7:0]       red;
		logic             bad;
		logic             done;
	} pix_cmd_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_dec_t;

	function automatic hex_dec_t hex_decode(input logic [7:0] c);
		hex_dec_t r;
		r.ok  = 1'b0;
		r.val = 4'd0;
		case (c) inside
			[8'h30:8'h39]: begin
				r.ok  = 1'b1;
				r.val = c[3:0];
			end
			[8'h41:8'h46], [8'h61:8'h66]: begin
				r.ok  = 1'b1;
				r.val = c[3:0] + 4'd9;
			end
			default: begin
				r.ok  = 1'b0;
				r.val = 4'd0;
			end
		endcase
		return r;
	endfunction

	// 255 - min(255, x + k)
	function automatic logic [7:0] cmyk_chan(input logic [7:0] x, input logic [7:0] k);
		logic [8:0] s;
		s = {1'b0, x} + {1'b0, k};
		return s[8] ? 8'd0 : (8'hFF - s[7:0]);
	endfunction

	// effective line count minus one, count clamped to 1..MAX_LINES
	function automatic logic [LI_W-1:0] last_line_of(input logic [LC_W-1:0] n);
		logic [LC_W-1:0] m;
		m = n - LC_W'(1);
		if (n == '0)
			return '0;
		else if (n > LC_W'(MAX_LINES))
			return LI_W'(MAX_LINES - 1);
		else
			return m[LI_W-1:0];
	endfunction

	function automatic logic [OFS_W-1:0] eff_stride(input logic [OFS_W-1:0] s);
		return (s > OFS_W'(MAX_STRIDE)) ? OFS_W'(MAX_STRIDE) : s;
	endfunction

endpackage

FILE: hdl/hpu_front.sv
// Front end: hex decode, channel gathering, scanline walk and sticky flags.
// Depends on hpu_pkg; emits one pix_cmd_t per accepted transfer.
`timescale 1ns / 1ps
`include "hex_pixel_unpacker_bgr_top_defines.svh"

module hpu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  hpu_pkg::cfg_t     cfg,
	input  hpu_pkg::li_load_t li_load,
	input  logic              in_take,
	input  logic [7:0]        hi_char,
	input  logic [7:0]        lo_char,
	output hpu_pkg::pix_cmd_t cmd
);

	logic [7:0]                 ch_q [4];
	logic [hpu_pkg::CNT_W-1:0]  cnt_q;
	logic [hpu_pkg::OFS_W-1:0]  row_q;
	logic [hpu_pkg::LI_W-1:0]   li_q;
	logic                       err_q;
	logic                       done_q;

	hpu_pkg::hex_dec_t          hi_d, lo_d;
	logic                       active, bad, complete, wrap, last_line;
	logic [7:0]                 byte_d;
	logic [7:0]                 ch_n [4];
	logic [hpu_pkg::CNT_W-1:0]  cnt_inc, need;
	logic [hpu_pkg::OFS_W:0]    row_sum;

	always_comb begin
		hi_d     = hpu_pkg::hex_decode(hi_char);
		lo_d     = hpu_pkg::hex_decode(lo_char);
		active   = !err_q && !done_q;
		bad      = !(hi_d.ok && lo_d.ok);
		byte_d   = {hi_d.val, lo_d.val};
		cnt_inc  = cnt_q + hpu_pkg::CNT_W'(1);
		need     = cfg.color_mode ? hpu_pkg::NEED_CMYK : hpu_pkg::NEED_RGB;
		complete = active && !bad && (cnt_inc >= need);
		row_sum  = {1'b0, row_q} + hpu_pkg::PIX_BYTES;
		wrap     = row_sum > {1'b0, cfg.row_last_offset};
		last_line = (li_q == '0);
		for (int i = 0; i < 4; i++)
			ch_n[i] = (cnt_q[1:0] == 2'(i)) ? byte_d : ch_q[i];
	end

	always_comb begin
		cmd          = '0;
		cmd.wr       = complete;
		cmd.bad      = err_q || (active && bad);
		cmd.done     = done_q || (complete && wrap && last_line);
		if (complete) begin
			cmd.line_idx = li_q;
			cmd.row_off  = row_q;
			if (cfg.color_mode) begin
				cmd.red   = hpu_pkg::cmyk_chan(ch_n[0], ch_n[3]);
				cmd.green = hpu_pkg::cmyk_chan(ch_n[1], ch_n[3]);
				cmd.blue  = hpu_pkg::cmyk_chan(ch_n[2], ch_n[3]);
			end else begin
				cmd.red   = ch_n[0];
				cmd.green = ch_n[1];
				cmd.blue  = ch_n[2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				ch_q[i] <= '0;
			cnt_q  <= '0;
			row_q  <= '0;
			li_q   <= '0;
			err_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (li_load.we) begin
			li_q <= li_load.last_line;
		end else if (in_take && active) begin
			if (bad) begin
				err_q <= 1'b1;
			end else begin
				ch_q[cnt_q[1:0]] <= byte_d;
				cnt_q <= complete ? '0 : cnt_inc;
				if (complete) begin
					row_q <= wrap ? '0 : row_sum[hpu_pkg::OFS_W-1:0];
					if (wrap) begin
						if (last_line)
							done_q <= 1'b1;
						else
							li_q <= li_q - hpu_pkg::LI_W'(1);
					end
				end
			end
		end
	end

	`HPU_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= hpu_pkg::NEED_RGB)
	`HPU_ASSERT_NXT(a_err_sticky, clk, arst_n, err_q && !li_load.we, err_q)
	`HPU_ASSERT_IMP(a_no_write_flagged, clk, arst_n, err_q || done_q, !cmd.wr)

endmodule

FILE: hdl/hpu_fifo.sv
// Four-entry queue of pixel commands between the front and back ends.
// Depends on hpu_pkg.
`timescale 1ns / 1ps
`include "hex_pixel_unpacker_bgr_top_defines.svh"

module hpu_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hpu_pkg::pix_cmd_t wdata,
	output logic              full,
	input  logic              pop,
	output hpu_pkg::pix_cmd_t rdata,
	output logic              empty
);

	hpu_pkg::pix_cmd_t            mem_q [hpu_pkg::FIFO_DEPTH];
	logic [hpu_pkg::FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [hpu_pkg::FIFO_CW-1:0]  count_q;

	assign full  = (count_q == hpu_pkg::FIFO_CW'(hpu_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + hpu_pkg::FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + hpu_pkg::FIFO_AW'(1);
			if (push && !pop)
				count_q <= count_q + hpu_pkg::FIFO_CW'(1);
			else if (pop && !push)
				count_q <= count_q - hpu_pkg::FIFO_CW'(1);
		end
	end

	`HPU_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`HPU_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty)
	`HPU_ASSERT_NXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 3'd1)

endmodule

FILE: hdl/hpu_back.sv
// Back end: address multiply, offset add and the result register.
// Depends on hpu_pkg; drains hpu_fifo, drives the result queue ports.
`timescale 1ns / 1ps
`include "hex_pixel_unpacker_bgr_top_defines.svh"

module hpu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hpu_pkg::cfg_t              cfg,
	input  logic                       q_empty,
	input  hpu_pkg::pix_cmd_t          q_data,
	output logic                       q_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic                       write_valid,
	output logic [hpu_pkg::ADDR_W-1:0] pixel_address,
	output logic [7:0]                 blue_byte,
	output logic [7:0]                 green_byte,
	output logic [7:0]                 red_byte,
	output logic                       bad_digit,
	output logic                       image_done
);

	// stage 1: product registered
	logic                        vld_s1;
	hpu_pkg::pix_cmd_t           cmd_s1;
	logic [hpu_pkg::ADDR_W-1:0]  prod_s1;
	// stage 2: result register
	logic                        vld_s2;
	hpu_pkg::pix_cmd_t           cmd_s2;
	logic [hpu_pkg::ADDR_W-1:0]  addr_s2;

	logic                        load_s1, load_s2;
	logic [hpu_pkg::OFS_W-1:0]   stride;

	assign stride  = hpu_pkg::eff_stride(cfg.line_stride);
	assign load_s2 = vld_s1 && (!vld_s2 || pop);
	assign load_s1 = !q_empty && (!vld_s1 || load_s2);
	assign q_pop   = load_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1  <= q_data;
			prod_s1 <= {14'd0, q_data.line_idx} * {12'd0, stride};
		end
		if (load_s2) begin
			cmd_s2  <= cmd_s1;
			addr_s2 <= prod_s1 + {12'd0, cmd_s1.row_off};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1)
				vld_s1 <= 1'b1;
			else if (load_s2)
				vld_s1 <= 1'b0;
			if (load_s2)
				vld_s2 <= 1'b1;
			else if (pop)
				vld_s2 <= 1'b0;
		end
	end

	assign empty         = !vld_s2;
	assign write_valid   = cmd_s2.wr;
	assign pixel_address = addr_s2;
	assign blue_byte     = cmd_s2.blue;
	assign green_byte    = cmd_s2.green;
	assign red_byte      = cmd_s2.red;
	assign bad_digit     = cmd_s2.bad;
	assign image_done    = cmd_s2.done;

	`HPU_ASSERT_NXT(a_s1_hold, clk, arst_n, vld_s1 && !load_s2 && !load_s1, vld_s1 && $stable(prod_s1))
	`HPU_ASSERT_IMP(a_idle_addr_zero, clk, arst_n, vld_s2 && !cmd_s2.wr, addr_s2 == '0)
	`HPU_ASSERT_IMP(a_s2_fed, clk, arst_n, load_s2, vld_s1)

endmodule

FILE: hdl/hex_pixel_unpacker_bgr_top.sv
// Top level of the hex pixel unpacker: register file, front, queue, back.
// Depends on hpu_pkg, hpu_front, hpu_fifo and hpu_back.
//
// channel   handshake              payload
// input     push / full            hi_char, lo_char
// result    pop / empty            write_valid, pixel_address, blue/green/red_byte,
//                                  bad_digit, image_done
// config    APB psel/penable/...   paddr[3:0], pwdata, prdata
//
// One transfer in per clock while full is low; each input transfer yields exactly one result.
// A pushed transfer passes through the queue, the multiply stage and the result
// register before empty falls; the 12x14 address multiply sets the stage boundary.
// A stalled result backs up through the 4-entry queue before full rises.
// Reset is asynchronous; the block takes items in the first cycle after it.
`timescale 1ns / 1ps

module hex_pixel_unpacker_bgr_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 hi_char,
	input  logic [7:0]                 lo_char,
	output logic                       empty,
	input  logic                       pop,
	output logic                       write_valid,
	output logic [hpu_pkg::ADDR_W-1:0] pixel_address,
	output logic [7:0]                 blue_byte,
	output logic [7:0]                 green_byte,
	output logic [7:0]                 red_byte,
	output logic                       bad_digit,
	output logic                       image_done,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	hpu_pkg::cfg_t      cfg_q;
	hpu_pkg::li_load_t  li_load;
	hpu_pkg::pix_cmd_t  cmd, q_data;
	hpu_pkg::reg_idx_t  idx;
	logic               cfg_we, in_take, q_full, q_empty, q_pop;

	assign pready  = 1'b1;
	assign idx     = hpu_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite;
	assign in_take = push && !q_full;
	assign full    = q_full;

	assign li_load.we        = cfg_we && (idx == hpu_pkg::REG_LINE_COUNT);
	assign li_load.last_line = hpu_pkg::last_line_of(pwdata[hpu_pkg::LC_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode      <= 1'b0;
			cfg_q.line_count      <= hpu_pkg::LC_W'(1);
			cfg_q.line_stride     <= hpu_pkg::OFS_W'(3);
			cfg_q.row_last_offset <= hpu_pkg::OFS_W'(2);
		end else if (cfg_we) begin
			case (idx)
				hpu_pkg::REG_COLOR_MODE:  cfg_q.color_mode      <= pwdata[0];
				hpu_pkg::REG_LINE_COUNT:  cfg_q.line_count      <= pwdata[hpu_pkg::LC_W-1:0];
				hpu_pkg::REG_LINE_STRIDE: cfg_q.line_stride     <= pwdata[hpu_pkg::OFS_W-1:0];
				hpu_pkg::REG_ROW_LAST:    cfg_q.row_last_offset <= pwdata[hpu_pkg::OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			hpu_pkg::REG_COLOR_MODE:  prdata = {31'd0, cfg_q.color_mode};
			hpu_pkg::REG_LINE_COUNT:  prdata = {19'd0, cfg_q.line_count};
			hpu_pkg::REG_LINE_STRIDE: prdata = {18'd0, cfg_q.line_stride};
			hpu_pkg::REG_ROW_LAST:    prdata = {18'd0, cfg_q.row_last_offset};
			default:                  prdata = '0;
		endcase
	end

	hpu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.li_load (li_load),
		.in_take (in_take),
		.hi_char (hi_char),
		.lo_char (lo_char),
		.cmd     (cmd)
	);

	hpu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_take),
		.wdata  (cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	hpu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.write_valid   (write_valid),
		.pixel_address (pixel_address),
		.blue_byte     (blue_byte),
		.green_byte    (green_byte),
		.red_byte      (red_byte),
		.bad_digit     (bad_digit),
		.image_done    (image_done)
	);

endmodule
